@@ hw/rtl/sflp_pkg.sv @@
package sflp_pkg;

   localparam int NUM_TYPES = 21;

   // type indices, in xcbB?hHiIlLqQnNefdspP order
   localparam logic [4:0] TYPE_PAD    = 5'd0;
   localparam logic [4:0] TYPE_CHAR   = 5'd1;
   localparam logic [4:0] TYPE_SCHAR  = 5'd2;
   localparam logic [4:0] TYPE_UCHAR  = 5'd3;
   localparam logic [4:0] TYPE_BOOL   = 5'd4;
   localparam logic [4:0] TYPE_SHORT  = 5'd5;
   localparam logic [4:0] TYPE_USHORT = 5'd6;
   localparam logic [4:0] TYPE_INT    = 5'd7;
   localparam logic [4:0] TYPE_UINT   = 5'd8;
   localparam logic [4:0] TYPE_LONG   = 5'd9;
   localparam logic [4:0] TYPE_ULONG  = 5'd10;
   localparam logic [4:0] TYPE_LLONG  = 5'd11;
   localparam logic [4:0] TYPE_ULLONG = 5'd12;
   localparam logic [4:0] TYPE_SSIZE  = 5'd13;
   localparam logic [4:0] TYPE_SIZE   = 5'd14;
   localparam logic [4:0] TYPE_HALF   = 5'd15;
   localparam logic [4:0] TYPE_FLOAT  = 5'd16;
   localparam logic [4:0] TYPE_DOUBLE = 5'd17;
   localparam logic [4:0] TYPE_STRING = 5'd18;
   localparam logic [4:0] TYPE_PSTR   = 5'd19;
   localparam logic [4:0] TYPE_PTR    = 5'd20;

   // byte-order codes
   localparam logic [2:0] MODE_NATIVE = 3'd0;
   localparam logic [2:0] MODE_STD    = 3'd1;
   localparam logic [2:0] MODE_LITTLE = 3'd2;
   localparam logic [2:0] MODE_BIG    = 3'd3;
   localparam logic [2:0] MODE_NET    = 3'd4;

   localparam int RES_MAX = 3;

   typedef struct packed {
      logic        kind;
      logic [4:0]  entry_type;
      logic [15:0] entry_count;
      logic [15:0] entry_size;
      logic [2:0]  entry_padding;
      logic [31:0] entry_offset;
      logic [31:0] packed_bytes;
      logic [31:0] value_count;
      logic [15:0] letter_count;
      logic [2:0]  byte_order;
      logic        format_error;
      logic        last;
   } rsp_type;

   // results of one transaction, packed from item[0] upward
   typedef struct packed {
      logic [1:0]            count;
      rsp_type [RES_MAX-1:0] item;
   } push_type;

   // {hit, index}
   function automatic logic [5:0] type_lookup(input logic [7:0] c);
      logic [5:0] r;
      case (c)
         "x":     r = {1'b1, TYPE_PAD};
         "c":     r = {1'b1, TYPE_CHAR};
         "b":     r = {1'b1, TYPE_SCHAR};
         "B":     r = {1'b1, TYPE_UCHAR};
         "?":     r = {1'b1, TYPE_BOOL};
         "h":     r = {1'b1, TYPE_SHORT};
         "H":     r = {1'b1, TYPE_USHORT};
         "i":     r = {1'b1, TYPE_INT};
         "I":     r = {1'b1, TYPE_UINT};
         "l":     r = {1'b1, TYPE_LONG};
         "L":     r = {1'b1, TYPE_ULONG};
         "q":     r = {1'b1, TYPE_LLONG};
         "Q":     r = {1'b1, TYPE_ULLONG};
         "n":     r = {1'b1, TYPE_SSIZE};
         "N":     r = {1'b1, TYPE_SIZE};
         "e":     r = {1'b1, TYPE_HALF};
         "f":     r = {1'b1, TYPE_FLOAT};
         "d":     r = {1'b1, TYPE_DOUBLE};
         "s":     r = {1'b1, TYPE_STRING};
         "p":     r = {1'b1, TYPE_PSTR};
         "P":     r = {1'b1, TYPE_PTR};
         default: r = {1'b0, TYPE_PAD};
      endcase
      return r;
   endfunction

   // {hit, mode}
   function automatic logic [3:0] mode_lookup(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         "@":     r = {1'b1, MODE_NATIVE};
         "=":     r = {1'b1, MODE_STD};
         "<":     r = {1'b1, MODE_LITTLE};
         ">":     r = {1'b1, MODE_BIG};
         "!":     r = {1'b1, MODE_NET};
         default: r = {1'b0, MODE_NATIVE};
      endcase
      return r;
   endfunction

   function automatic logic [3:0] elem_size(input logic [4:0] t);
      logic [3:0] r;
      case (t)
         TYPE_CHAR, TYPE_SCHAR, TYPE_UCHAR, TYPE_BOOL:          r = 4'd1;
         TYPE_SHORT, TYPE_USHORT, TYPE_HALF:                    r = 4'd2;
         TYPE_INT, TYPE_UINT, TYPE_LONG, TYPE_ULONG,
         TYPE_SSIZE, TYPE_SIZE, TYPE_FLOAT, TYPE_PTR:           r = 4'd4;
         TYPE_LLONG, TYPE_ULLONG, TYPE_DOUBLE:                  r = 4'd8;
         default:                                               r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_aligned(input logic [4:0] t);
      return ((t >= TYPE_SCHAR) && (t <= TYPE_DOUBLE)) || (t == TYPE_PTR);
   endfunction

endpackage

@@ hw/rtl/sflp_if.sv @@
interface sflp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] fmt_char;
   logic       is_last;

   modport source(output valid, fmt_char, is_last, input ready);
   modport sink(input valid, fmt_char, is_last, output ready);
endinterface

interface sflp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [4:0]  entry_type;
   logic [15:0] entry_count;
   logic [15:0] entry_size;
   logic [2:0]  entry_padding;
   logic [31:0] entry_offset;
   logic [31:0] packed_bytes;
   logic [31:0] value_count;
   logic [15:0] letter_count;
   logic [2:0]  byte_order;
   logic        format_error;
   logic        last;

   modport source(output valid, kind, entry_type, entry_count, entry_size, entry_padding,
                  entry_offset, packed_bytes, value_count, letter_count, byte_order,
                  format_error, last, input ready);
   modport sink(input valid, kind, entry_type, entry_count, entry_size, entry_padding,
                entry_offset, packed_bytes, value_count, letter_count, byte_order,
                format_error, last, output ready);
endinterface

@@ hw/rtl/sflp_parse.sv @@
module sflp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         fmt_char,
   input  logic               is_last,
   output sflp_pkg::push_type push
);

   logic        at_start_ff, at_start_in;
   logic [2:0]  order_mode_ff, order_mode_in;
   logic        count_seen_ff, count_seen_in;
   logic [15:0] count_accum_ff, count_accum_in;
   logic        held_valid_ff, held_valid_in;
   logic [4:0]  held_type_ff, held_type_in;
   logic [15:0] held_count_ff, held_count_in;
   logic [15:0] held_size_ff, held_size_in;
   logic [2:0]  held_padding_ff, held_padding_in;
   logic [31:0] running_offset_ff, running_offset_in;
   logic [31:0] item_total_ff, item_total_in;
   logic [15:0] entry_total_ff, entry_total_in;
   logic        error_seen_ff, error_seen_in;

   logic [3:0]  mode_res;
   logic [5:0]  type_res;
   logic [4:0]  t_idx;
   logic [3:0]  ts;
   logic [2:0]  mask;
   logic        consumed, active, is_blank, is_digit, letter, bad, err_new, native;
   logic [2:0]  mode_cur;
   logic [15:0] cnt, sz, items_add;
   logic [2:0]  rm, grow, pad_new;
   logic [15:0] e1_size;
   logic        e1_v, e2_v;
   logic [31:0] ro1, ro2;
   sflp_pkg::rsp_type e1, e2, summ;

   always_comb begin
      mode_res = sflp_pkg::mode_lookup(fmt_char);
      type_res = sflp_pkg::type_lookup(fmt_char);
      t_idx    = type_res[4:0];
      ts       = sflp_pkg::elem_size(t_idx);
      mask     = 3'(ts - 4'd1);

      consumed = !error_seen_ff && at_start_ff && mode_res[3];
      mode_cur = consumed ? mode_res[2:0] : order_mode_ff;
      native   = (mode_cur == sflp_pkg::MODE_NATIVE);
      active   = !error_seen_ff && !consumed;
      is_blank = (fmt_char == " ") || (fmt_char == 8'h09);
      is_digit = (fmt_char >= "0") && (fmt_char <= "9");
      letter   = active && !is_blank && !is_digit && type_res[5];
      bad      = active && ((is_blank && count_seen_ff) ||
                            (!is_blank && !is_digit && !type_res[5]));
      err_new  = error_seen_ff || bad;

      cnt = count_seen_ff ? count_accum_ff : 16'd1;
      case (ts)
         4'd2:    sz = {cnt[14:0], 1'b0};
         4'd4:    sz = {cnt[13:0], 2'b0};
         4'd8:    sz = {cnt[12:0], 3'b0};
         default: sz = cnt;
      endcase
      if (ts != 4'd0) begin
         items_add = cnt;
      end else begin
         items_add = (t_idx != sflp_pkg::TYPE_PAD) ? 16'd1 : 16'd0;
      end

      // in native mode a held pad run grows so the new entry lands on its own alignment
      rm   = 3'(running_offset_ff[2:0] + held_size_ff[2:0]) & mask;
      grow = (native && (held_type_ff == sflp_pkg::TYPE_PAD) && (ts != 4'd0) && (rm != 3'd0))
             ? 3'(ts - {1'b0, rm}) : 3'd0;
      e1_size = held_size_ff + {13'd0, grow};
      e1_v    = letter && held_valid_ff;
      ro1     = e1_v ? running_offset_ff + {16'd0, e1_size} + {29'd0, held_padding_ff}
                     : running_offset_ff;
      pad_new = (native && sflp_pkg::is_aligned(t_idx)) ? ((~ro1[2:0] + 3'd1) & mask) : 3'd0;

      // defaults: hold
      at_start_in       = at_start_ff;
      order_mode_in     = mode_cur;
      count_seen_in     = count_seen_ff;
      count_accum_in    = count_accum_ff;
      held_valid_in     = held_valid_ff;
      held_type_in      = held_type_ff;
      held_count_in     = held_count_ff;
      held_size_in      = held_size_ff;
      held_padding_in   = held_padding_ff;
      running_offset_in = ro1;
      item_total_in     = item_total_ff;
      entry_total_in    = entry_total_ff;
      error_seen_in     = err_new;

      if (!error_seen_ff) begin
         at_start_in = 1'b0;
      end
      if (active && is_digit) begin
         count_seen_in  = 1'b1;
         count_accum_in = {count_accum_ff[12:0], 3'b0} + {count_accum_ff[14:0], 1'b0}
                          + {12'd0, 4'(fmt_char - "0")};
      end
      if (letter) begin
         held_valid_in   = 1'b1;
         held_type_in    = t_idx;
         held_count_in   = cnt;
         held_size_in    = sz;
         held_padding_in = pad_new;
         entry_total_in  = entry_total_ff + 16'd1;
         item_total_in   = item_total_ff + {16'd0, items_add};
         count_seen_in   = 1'b0;
         count_accum_in  = 16'd0;
      end
      if (err_new) begin
         held_valid_in = 1'b0;
      end

      e2_v = is_last && held_valid_in;
      ro2  = e2_v ? ro1 + {16'd0, held_size_in} + {29'd0, held_padding_in} : ro1;

      e1 = '0;
      e1.entry_type    = held_type_ff;
      e1.entry_count   = held_count_ff;
      e1.entry_size    = e1_size;
      e1.entry_padding = held_padding_ff;
      e1.entry_offset  = running_offset_ff;
      e1.byte_order    = mode_cur;

      e2 = '0;
      e2.entry_type    = held_type_in;
      e2.entry_count   = held_count_in;
      e2.entry_size    = held_size_in;
      e2.entry_padding = held_padding_in;
      e2.entry_offset  = ro1;
      e2.byte_order    = mode_cur;

      summ = '0;
      summ.kind         = 1'b1;
      summ.last         = 1'b1;
      summ.byte_order   = mode_cur;
      summ.format_error = err_new;
      if (!err_new) begin
         summ.packed_bytes = ro2;
         summ.value_count  = item_total_in;
         summ.letter_count = entry_total_in;
      end

      push.item[2] = summ;
      push.item[1] = e1_v ? (e2_v ? e2 : summ) : summ;
      push.item[0] = e1_v ? e1 : (e2_v ? e2 : summ);
      push.count   = accept ? (2'({1'b0, e1_v}) + 2'({1'b0, e2_v}) + 2'({1'b0, is_last}))
                            : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && is_last)) begin
         at_start_ff       <= 1'b1;
         order_mode_ff     <= sflp_pkg::MODE_NATIVE;
         count_seen_ff     <= 1'b0;
         count_accum_ff    <= '0;
         held_valid_ff     <= 1'b0;
         held_type_ff      <= sflp_pkg::TYPE_PAD;
         held_count_ff     <= '0;
         held_size_ff      <= '0;
         held_padding_ff   <= '0;
         running_offset_ff <= '0;
         item_total_ff     <= '0;
         entry_total_ff    <= '0;
         error_seen_ff     <= 1'b0;
      end else if (accept) begin
         at_start_ff       <= at_start_in;
         order_mode_ff     <= order_mode_in;
         count_seen_ff     <= count_seen_in;
         count_accum_ff    <= count_accum_in;
         held_valid_ff     <= held_valid_in;
         held_type_ff      <= held_type_in;
         held_count_ff     <= held_count_in;
         held_size_ff      <= held_size_in;
         held_padding_ff   <= held_padding_in;
         running_offset_ff <= running_offset_in;
         item_total_ff     <= item_total_in;
         entry_total_ff    <= entry_total_in;
         error_seen_ff     <= error_seen_in;
      end
   end

endmodule

@@ hw/rtl/sflp_outq.sv @@
module sflp_outq #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  sflp_pkg::push_type push,
   input  logic               out_ready,
   output logic               out_valid,
   output sflp_pkg::rsp_type  head,
   output logic               can_accept
);

   localparam int CW = $clog2(DEPTH + 1);

   sflp_pkg::rsp_type q_ff [DEPTH];
   sflp_pkg::rsp_type q_in [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] base;
   logic          pop;

   always_comb begin
      pop  = (count_ff != '0) && out_ready;
      base = count_ff - CW'(pop);
      for (int i = 0; i < DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      // new results fill in right behind what remains
      for (int i = 0; i < DEPTH; i++) begin
         for (int k = 0; k < sflp_pkg::RES_MAX; k++) begin
            if ((CW'(k) < CW'(push.count)) && (CW'(i) == base + CW'(k))) begin
               q_in[i] = push.item[k];
            end
         end
      end
      count_in = base + CW'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign out_valid  = (count_ff != '0);
   assign head       = q_ff[0];
   assign can_accept = (count_ff <= CW'(DEPTH - sflp_pkg::RES_MAX));

endmodule

@@ hw/rtl/struct_format_layout_parser.sv @@
// A result is offered on rsp_if the cycle after its byte is taken,
//   behind any results still queued.
// Throughput: one format byte per cycle while each byte yields at most one result and the
//   sink keeps up; a byte yielding two or three results holds off later bytes until the queue drains.
// Rate is set by the single-read-port output queue of QUEUE_DEPTH entries.
// Reset (synchronous, active high) clears parser state and empties the queue.
module struct_format_layout_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic        clock,
   input logic        reset,
   sflp_req_if.sink   req_if,
   sflp_rsp_if.source rsp_if
);

   sflp_pkg::push_type push;
   sflp_pkg::rsp_type  head;
   logic               accept;
   logic               can_accept;

   assign req_if.ready = can_accept;
   assign accept       = req_if.valid && can_accept;

   sflp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .fmt_char (req_if.fmt_char),
      .is_last  (req_if.is_last),
      .push     (push)
   );

   sflp_outq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .out_ready  (rsp_if.ready),
      .out_valid  (rsp_if.valid),
      .head       (head),
      .can_accept (can_accept)
   );

   assign rsp_if.kind          = head.kind;
   assign rsp_if.entry_type    = head.entry_type;
   assign rsp_if.entry_count   = head.entry_count;
   assign rsp_if.entry_size    = head.entry_size;
   assign rsp_if.entry_padding = head.entry_padding;
   assign rsp_if.entry_offset  = head.entry_offset;
   assign rsp_if.packed_bytes  = head.packed_bytes;
   assign rsp_if.value_count   = head.value_count;
   assign rsp_if.letter_count  = head.letter_count;
   assign rsp_if.byte_order    = head.byte_order;
   assign rsp_if.format_error  = head.format_error;
   assign rsp_if.last          = head.last;

endmodule

@@ hw/rtl/sflp_checker.sv @@
module sflp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic        rsp_last,
   input logic        rsp_format_error,
   input logic [31:0] rsp_packed_bytes,
   input logic [31:0] rsp_value_count,
   input logic [15:0] rsp_letter_count
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_last != rsp_kind) |-> 1'b0)
      else $error("last flag and summary kind disagree");

   a_error_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_format_error |->
         rsp_kind && (rsp_packed_bytes == '0) && (rsp_value_count == '0) &&
         (rsp_letter_count == '0))
      else $error("rejected format reports totals");

endmodule

bind struct_format_layout_parser sflp_checker u_sflp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_kind         (rsp_if.kind),
   .rsp_last         (rsp_if.last),
   .rsp_format_error (rsp_if.format_error),
   .rsp_packed_bytes (rsp_if.packed_bytes),
   .rsp_value_count  (rsp_if.value_count),
   .rsp_letter_count (rsp_if.letter_count)
);
